>>> hdl/binary_trie_longest_prefix_match_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binary trie longest prefix match block
// Concurrent checks that are clocked and disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef BINARY_TRIE_LONGEST_PREFIX_MATCH_ASSERT_SVH
`define BINARY_TRIE_LONGEST_PREFIX_MATCH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTLPM_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BTLPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/btlpm_pkg.sv
// ----------------------------------------------------------------------------
// Binary trie longest prefix match package
// Shared widths, codes, transfer payload types and the sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package btlpm_pkg;

    localparam int KEY_BITS   = 32;
    localparam int KEY_IDX_W  = $clog2(KEY_BITS);
    localparam int LEN_W      = 6;
    localparam int ROUTE_W    = 16;
    localparam int STATUS_W   = 2;
    localparam int NODE_COUNT = 1024;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic               opcode;
        logic [KEY_BITS-1:0] key;
        logic [LEN_W-1:0]   key_len;
        logic [ROUTE_W-1:0] route_index;
    } in_item_t;

    typedef struct packed {
        logic                found;
        logic [ROUTE_W-1:0]  match_index;
        logic [STATUS_W-1:0] status;
    } out_item_t;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

endpackage

`default_nettype wire

>>> hdl/btlpm_walk.sv
// ----------------------------------------------------------------------------
// Trie walk engine
// Holds the node memory and walks it one key bit per cycle for inserts and
// lookups, allocating new nodes from a linear pool.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btlpm_walk #(
    parameter int NODE_COUNT = btlpm_pkg::NODE_COUNT
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  btlpm_pkg::in_item_t  s_data,
    output logic                 res_valid,
    input  wire                  res_ready,
    output btlpm_pkg::out_item_t res_data
);

    localparam int IDX_W    = $clog2(NODE_COUNT);
    localparam int CNT_W    = IDX_W + 1;
    localparam int ROUTE_W  = btlpm_pkg::ROUTE_W;
    localparam int LEN_W    = btlpm_pkg::LEN_W;
    localparam int KEY_BITS = btlpm_pkg::KEY_BITS;
    localparam int KIDX_W   = btlpm_pkg::KEY_IDX_W;
    localparam int ENTRY_W  = 2 * IDX_W + 1 + ROUTE_W;
    localparam int C1_LSB   = IDX_W + 1 + ROUTE_W;
    localparam int C0_LSB   = 1 + ROUTE_W;
    localparam int MARK_POS = ROUTE_W;

    // Node memory: child one link, child zero link, mark, route index.
    // The root lives in registers so that reset empties the trie at once.
    logic [ENTRY_W-1:0] node_mem [NODE_COUNT];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_wa;
    logic [ENTRY_W-1:0] mem_wd;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_ra;

    btlpm_pkg::state_t  state_reg, state_next;
    logic               op_reg, op_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   depth_reg, depth_next;
    logic [ROUTE_W-1:0] route_reg, route_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic               cur_root_reg, cur_root_next;
    logic               cur_new_reg, cur_new_next;
    logic               hit_reg, hit_next;
    logic [ROUTE_W-1:0] hit_route_reg, hit_route_next;
    logic [CNT_W-1:0]   free_reg, free_next;
    logic [IDX_W-1:0]   root_c0_reg, root_c0_next;
    logic [IDX_W-1:0]   root_c1_reg, root_c1_next;

    logic [ENTRY_W-1:0] cur_data;
    logic [ENTRY_W-1:0] upd_data;
    logic               key_bit;
    logic [IDX_W-1:0]   child;
    logic               node_mark;
    logic               hit_now;
    logic [ROUTE_W-1:0] route_now;
    logic               at_end;
    logic               pool_full;
    logic [LEN_W-1:0]   len_sat;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            node_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= node_mem[mem_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= btlpm_pkg::ST_IDLE;
            free_reg    <= CNT_W'(1);
            root_c0_reg <= '0;
            root_c1_reg <= '0;
        end else begin
            state_reg   <= state_next;
            free_reg    <= free_next;
            root_c0_reg <= root_c0_next;
            root_c1_reg <= root_c1_next;
        end
        op_reg        <= op_next;
        key_reg       <= key_next;
        len_reg       <= len_next;
        depth_reg     <= depth_next;
        route_reg     <= route_next;
        cur_reg       <= cur_next;
        cur_root_reg  <= cur_root_next;
        cur_new_reg   <= cur_new_next;
        hit_reg       <= hit_next;
        hit_route_reg <= hit_route_next;
    end

    // A freshly allocated node has not been written yet and reads as empty.
    always_comb begin
        if (cur_root_reg) begin
            cur_data = '0;
            cur_data[C1_LSB +: IDX_W] = root_c1_reg;
            cur_data[C0_LSB +: IDX_W] = root_c0_reg;
        end else if (cur_new_reg) begin
            cur_data = '0;
        end else begin
            cur_data = rd_data_reg;
        end
    end

    assign key_bit   = key_reg[KIDX_W'(KEY_BITS - 1) - depth_reg[KIDX_W-1:0]];
    assign child     = key_bit ? cur_data[C1_LSB +: IDX_W] : cur_data[C0_LSB +: IDX_W];
    assign node_mark = !cur_root_reg && cur_data[MARK_POS];
    assign hit_now   = hit_reg || node_mark;
    assign route_now = node_mark ? cur_data[ROUTE_W-1:0] : hit_route_reg;
    assign at_end    = (depth_reg == len_reg);
    assign pool_full = (free_reg >= CNT_W'(NODE_COUNT));
    assign len_sat   = (s_data.key_len > LEN_W'(KEY_BITS)) ? LEN_W'(KEY_BITS)
                                                          : s_data.key_len;

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        len_next       = len_reg;
        depth_next     = depth_reg;
        route_next     = route_reg;
        cur_next       = cur_reg;
        cur_root_next  = cur_root_reg;
        cur_new_next   = cur_new_reg;
        hit_next       = hit_reg;
        hit_route_next = hit_route_reg;
        free_next      = free_reg;
        root_c0_next   = root_c0_reg;
        root_c1_next   = root_c1_reg;
        mem_we         = 1'b0;
        mem_wa         = cur_reg;
        mem_wd         = '0;
        mem_re         = 1'b0;
        mem_ra         = child;
        upd_data       = cur_data;
        s_ready        = 1'b0;
        res_valid      = 1'b0;
        res_data       = '0;

        case (state_reg)
            btlpm_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next        = s_data.opcode;
                    key_next       = s_data.key;
                    len_next       = len_sat;
                    route_next     = s_data.route_index;
                    depth_next     = '0;
                    cur_next       = '0;
                    cur_root_next  = 1'b1;
                    cur_new_next   = 1'b0;
                    hit_next       = 1'b0;
                    hit_route_next = '0;
                    state_next     = btlpm_pkg::ST_WALK;
                end
            end

            btlpm_pkg::ST_WALK: begin
                if (op_reg == btlpm_pkg::OP_LOOKUP) begin
                    if (at_end || child == '0) begin
                        res_valid            = 1'b1;
                        res_data.found       = hit_now;
                        res_data.match_index = hit_now ? route_now : '0;
                        res_data.status      = btlpm_pkg::STATUS_OK;
                        if (res_ready) begin
                            state_next = btlpm_pkg::ST_IDLE;
                        end
                    end else begin
                        hit_next       = hit_now;
                        hit_route_next = route_now;
                        cur_next       = child;
                        cur_root_next  = 1'b0;
                        cur_new_next   = 1'b0;
                        depth_next     = depth_reg + LEN_W'(1);
                        mem_re         = 1'b1;
                    end
                end else if (at_end) begin
                    // The final node takes the mark; a zero-length insert
                    // ends at the root and changes nothing.
                    res_valid       = 1'b1;
                    res_data.status = (len_reg == '0) ? btlpm_pkg::STATUS_EMPTY
                                                      : btlpm_pkg::STATUS_OK;
                    upd_data[MARK_POS]      = 1'b1;
                    upd_data[ROUTE_W-1:0]   = route_reg;
                    mem_wd                  = upd_data;
                    if (res_ready) begin
                        mem_we     = (len_reg != '0);
                        state_next = btlpm_pkg::ST_IDLE;
                    end
                end else if (child != '0) begin
                    cur_next      = child;
                    cur_root_next = 1'b0;
                    cur_new_next  = 1'b0;
                    depth_next    = depth_reg + LEN_W'(1);
                    mem_re        = 1'b1;
                end else if (pool_full) begin
                    // A new node that is left at the end of the chain is
                    // written out empty so that later walks see no children.
                    res_valid       = 1'b1;
                    res_data.status = btlpm_pkg::STATUS_FULL;
                    mem_wd          = '0;
                    if (res_ready) begin
                        mem_we     = cur_new_reg;
                        state_next = btlpm_pkg::ST_IDLE;
                    end
                end else begin
                    if (key_bit) begin
                        upd_data[C1_LSB +: IDX_W] = free_reg[IDX_W-1:0];
                    end else begin
                        upd_data[C0_LSB +: IDX_W] = free_reg[IDX_W-1:0];
                    end
                    if (cur_root_reg) begin
                        if (key_bit) begin
                            root_c1_next = free_reg[IDX_W-1:0];
                        end else begin
                            root_c0_next = free_reg[IDX_W-1:0];
                        end
                    end else begin
                        mem_we = 1'b1;
                        mem_wd = upd_data;
                    end
                    cur_next      = free_reg[IDX_W-1:0];
                    cur_root_next = 1'b0;
                    cur_new_next  = 1'b1;
                    free_next     = free_reg + CNT_W'(1);
                    depth_next    = depth_reg + LEN_W'(1);
                end
            end

            default: begin
                state_next = btlpm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/binary_trie_longest_prefix_match.sv
// Each item walks the trie with the single node memory read per key bit that the
// walk performs, and its result is registered on the output. The walk takes no
// new item until it has handed the result of the last one to the output
// register.
// Reset: synchronous and active low; it empties the trie by clearing the root
// links and setting the node pool counter back to one.
// ----------------------------------------------------------------------------
// Binary trie longest prefix match
// Inserts route prefixes into a binary trie held in one node memory and
// returns the route index of the longest stored prefix of a lookup key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "binary_trie_longest_prefix_match_assert.svh"

module binary_trie_longest_prefix_match #(
    parameter int NODE_COUNT = btlpm_pkg::NODE_COUNT
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  btlpm_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output btlpm_pkg::out_item_t m_data
);

    logic                 res_valid;
    logic                 res_ready;
    btlpm_pkg::out_item_t res_data;

    logic                 m_valid_reg, m_valid_next;
    btlpm_pkg::out_item_t m_data_reg, m_data_next;

    btlpm_walk #(
        .NODE_COUNT(NODE_COUNT)
    ) u_walk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // The output register frees itself in the cycle its result is taken.
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            m_data_next  = res_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `BTLPM_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "input accepted while a walk was starting")
    `BTLPM_ASSERT_SAME(a_miss_index_zero, aclk, aresetn, m_valid && !m_data.found, m_data.match_index == '0, "miss result carries a route index")
    `BTLPM_ASSERT_SAME(a_hit_status_ok, aclk, aresetn, m_valid && m_data.found, m_data.status == btlpm_pkg::STATUS_OK, "hit result carries an insert status")

endmodule

`default_nettype wire

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for the binary trie longest prefix match block
// Drives prefix inserts and lookups through the input channel. A software copy
// of the trie predicts every result, and each result transfer is checked
// against it field by field. Both channels are throttled at random but in the last phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class route_trie_model;

    int unsigned                       zero_link [btlpm_pkg::NODE_COUNT];
    int unsigned                       one_link  [btlpm_pkg::NODE_COUNT];
    bit                                marked    [btlpm_pkg::NODE_COUNT];
    logic [btlpm_pkg::ROUTE_W-1:0]     route_at  [btlpm_pkg::NODE_COUNT];
    int unsigned                       free_node;
    btlpm_pkg::out_item_t              expected_replies [$];
    int                                mismatches;

    function new();
        zero_link[0] = 0;
        one_link[0]  = 0;
        marked[0]    = 1'b0;
        route_at[0]  = '0;
        free_node    = 1;
        mismatches   = 0;
    endfunction

    // Works out the reply to an accepted request and updates the trie copy.
    function void apply_request(btlpm_pkg::in_item_t req);
        btlpm_pkg::out_item_t reply;
        int unsigned          depth;
        int unsigned          cur;
        int unsigned          nxt;
        bit                   b;
        depth = (req.key_len > btlpm_pkg::KEY_BITS) ? btlpm_pkg::KEY_BITS : req.key_len;
        reply = '0;
        cur   = 0;
        if (req.opcode == btlpm_pkg::OP_INSERT) begin
            if (depth == 0) begin
                reply.status = btlpm_pkg::STATUS_EMPTY;
            end else begin
                for (int unsigned i = 0; i < depth; i++) begin
                    b   = req.key[btlpm_pkg::KEY_BITS-1-i];
                    nxt = b ? one_link[cur] : zero_link[cur];
                    if (nxt == 0) begin
                        // Nodes taken so far stay linked but unmarked.
                        if (free_node >= btlpm_pkg::NODE_COUNT) begin
                            reply.status = btlpm_pkg::STATUS_FULL;
                            break;
                        end
                        nxt            = free_node;
                        free_node      = free_node + 1;
                        zero_link[nxt] = 0;
                        one_link[nxt]  = 0;
                        marked[nxt]    = 1'b0;
                        route_at[nxt]  = '0;
                        if (b) begin
                            one_link[cur] = nxt;
                        end else begin
                            zero_link[cur] = nxt;
                        end
                    end
                    cur = nxt;
                end
                if (reply.status == btlpm_pkg::STATUS_OK) begin
                    marked[cur]   = 1'b1;
                    route_at[cur] = req.route_index;
                end
            end
        end else begin
            for (int unsigned i = 0; i < depth; i++) begin
                b   = req.key[btlpm_pkg::KEY_BITS-1-i];
                nxt = b ? one_link[cur] : zero_link[cur];
                if (nxt == 0) begin
                    break;
                end
                cur = nxt;
                if (marked[cur]) begin
                    reply.found       = 1'b1;
                    reply.match_index = route_at[cur];
                end
            end
        end
        expected_replies.push_back(reply);
    endfunction

    function void compare_reply(btlpm_pkg::out_item_t got);
        btlpm_pkg::out_item_t want;
        if (expected_replies.size() == 0) begin
            $display("%0t ns: result transfer with none expected, actual %p", $time, got);
            mismatches++;
            return;
        end
        want = expected_replies.pop_front();
        if (got.found !== want.found) begin
            $display("%0t ns: found expected %0d actual %0d", $time, want.found, got.found);
            mismatches++;
        end
        if (got.match_index !== want.match_index) begin
            $display("%0t ns: match_index expected 0x%04h actual 0x%04h",
                     $time, want.match_index, got.match_index);
            mismatches++;
        end
        if (got.status !== want.status) begin
            $display("%0t ns: status expected %0d actual %0d", $time, want.status, got.status);
            mismatches++;
        end
    endfunction

endclass

module testbench;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 400;
    localparam int DRAIN_CYCLES    = 40;

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    btlpm_pkg::in_item_t  s_data  = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    btlpm_pkg::out_item_t m_data;

    int unsigned         send_idle_pct  = 14;
    int unsigned         recv_stall_pct = 69;
    int unsigned         cycle_count    = 0;
    logic [31:0]         trunk_keys [8];
    btlpm_pkg::in_item_t known_prefixes [$];
    route_trie_model     trie = new();

    binary_trie_longest_prefix_match i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            trie.compare_reply(m_data);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic btlpm_pkg::in_item_t request(logic op, logic [31:0] key,
                                                    int unsigned len,
                                                    logic [btlpm_pkg::ROUTE_W-1:0] route);
        btlpm_pkg::in_item_t req;
        req.opcode      = op;
        req.key         = key;
        req.key_len     = len[btlpm_pkg::LEN_W-1:0];
        req.route_index = route;
        return req;
    endfunction

    // Inserts mostly grow a few shared branches so that lookups find deep
    // matches; lookups mostly revisit stored prefixes with random low bits.
    function automatic btlpm_pkg::in_item_t random_request();
        btlpm_pkg::in_item_t req;
        btlpm_pkg::in_item_t stored;
        int unsigned         pick;
        int unsigned         depth;
        logic [31:0]         low_mask;
        req.route_index = btlpm_pkg::ROUTE_W'($urandom_range(65535));
        pick            = $urandom_range(99);
        if ($urandom_range(1) == 0) begin
            req.opcode = btlpm_pkg::OP_INSERT;
            if ($urandom_range(9) < 6) begin
                req.key = trunk_keys[$urandom_range(7)] ^ ($urandom >> $urandom_range(31, 4));
            end else begin
                req.key = $urandom;
            end
            if (pick < 8) begin
                req.key_len = '0;
            end else if (pick < 68) begin
                req.key_len = btlpm_pkg::LEN_W'($urandom_range(12, 1));
            end else if (pick < 90) begin
                req.key_len = btlpm_pkg::LEN_W'($urandom_range(32, 13));
            end else begin
                req.key_len = btlpm_pkg::LEN_W'($urandom_range(63, 33));
            end
            known_prefixes.push_back(req);
        end else begin
            req.opcode = btlpm_pkg::OP_LOOKUP;
            if (known_prefixes.size() > 0 && $urandom_range(9) < 7) begin
                stored   = known_prefixes[$urandom_range(known_prefixes.size() - 1)];
                depth    = (stored.key_len > btlpm_pkg::KEY_BITS) ? btlpm_pkg::KEY_BITS
                                                                   : stored.key_len;
                low_mask = 32'hFFFF_FFFF >> depth;
                req.key  = (stored.key & ~low_mask) | ($urandom & low_mask);
            end else begin
                req.key = $urandom;
            end
            if (pick < 5) begin
                req.key_len = '0;
            end else if (pick < 75) begin
                req.key_len = btlpm_pkg::LEN_W'($urandom_range(32, 16));
            end else if (pick < 90) begin
                req.key_len = btlpm_pkg::LEN_W'($urandom_range(15, 1));
            end else begin
                req.key_len = btlpm_pkg::LEN_W'($urandom_range(63, 33));
            end
        end
        return req;
    endfunction

    task automatic drive_request(btlpm_pkg::in_item_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        trie.apply_request(req);
        @(negedge aclk);
    endtask

    initial begin
        btlpm_pkg::in_item_t directed [$];
        foreach (trunk_keys[k]) begin
            trunk_keys[k] = $urandom;
        end
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        directed.push_back(request(btlpm_pkg::OP_INSERT, 32'h0000_0000, 0,  16'h1111));
        directed.push_back(request(btlpm_pkg::OP_LOOKUP, 32'h0000_0000, 0,  16'h0000));
        directed.push_back(request(btlpm_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32, 16'h0000));
        directed.push_back(request(btlpm_pkg::OP_INSERT, 32'hFFFF_FFFF, 32, 16'hFFFF));
        directed.push_back(request(btlpm_pkg::OP_INSERT, 32'h0000_0000, 32, 16'h0000));
        directed.push_back(request(btlpm_pkg::OP_INSERT, 32'h8000_0000, 1,  16'h0001));
        directed.push_back(request(btlpm_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32, 16'hFFFF));
        directed.push_back(request(btlpm_pkg::OP_LOOKUP, 32'hFFFF_0000, 32, 16'h0000));
        directed.push_back(request(btlpm_pkg::OP_INSERT, 32'h8000_0000, 1,  16'h1234));
        directed.push_back(request(btlpm_pkg::OP_LOOKUP, 32'hC000_0000, 63, 16'h0000));
        directed.push_back(request(btlpm_pkg::OP_INSERT, 32'h1234_5678, 63, 16'h5678));
        directed.push_back(request(btlpm_pkg::OP_LOOKUP, 32'h1234_5678, 32, 16'h0000));
        directed.push_back(request(btlpm_pkg::OP_LOOKUP, 32'h1234_5678, 31, 16'h0000));
        directed.push_back(request(btlpm_pkg::OP_LOOKUP, 32'h0000_0000, 31, 16'h0000));
        directed.push_back(request(btlpm_pkg::OP_LOOKUP, 32'h0000_0000, 40, 16'hFFFF));
        directed.push_back(request(btlpm_pkg::OP_INSERT, 32'hAAAA_AAAA, 16, 16'hA5A5));
        directed.push_back(request(btlpm_pkg::OP_LOOKUP, 32'hAAAA_FFFF, 20, 16'h0000));
        directed.push_back(request(btlpm_pkg::OP_INSERT, 32'h5555_5555, 32, 16'h5A5A));
        directed.push_back(request(btlpm_pkg::OP_LOOKUP, 32'h5555_5555, 47, 16'h0000));
        directed.push_back(request(btlpm_pkg::OP_INSERT, 32'h5555_5555, 32, 16'h0000));
        directed.push_back(request(btlpm_pkg::OP_LOOKUP, 32'h5555_5555, 32, 16'h0000));
        directed.push_back(request(btlpm_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 1,  16'h0000));
        foreach (directed[k]) begin
            drive_request(directed[k]);
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 14;
                    recv_stall_pct = 69;
                end
                1: begin
                    send_idle_pct  = 69;
                    recv_stall_pct = 14;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            repeat (ITEMS_PER_PHASE) begin
                drive_request(random_request());
            end
        end
        s_valid <= 1'b0;

        while (trie.expected_replies.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (trie.mismatches == 0 && trie.expected_replies.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
